FILE: src/cvsd_codec_loopback_unit_assert.svh
// Assertion macros for the CVSD codec loopback block.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef CVSD_CODEC_LOOPBACK_UNIT_ASSERT_SVH
`define CVSD_CODEC_LOOPBACK_UNIT_ASSERT_SVH

`ifndef SYNTH
// Same-cycle implication under reset
`define CVSD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cvsd check failed: same-cycle implication");
// Next-cycle implication under reset
`define CVSD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cvsd check failed: next-cycle implication");
`else
`define CVSD_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define CVSD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: src/cvsd_pkg.sv
// Constants, types and helper functions for the CVSD codec loopback block.
// No dependencies; imported by the interfaces and all modules.
package cvsd_pkg;

    localparam logic [15:0] ENC_LEAK       = 16'd30782;
    localparam logic [15:0] DEC_LEAK       = 16'd32260;
    localparam logic [15:0] W_STEP         = 16'd32260;
    localparam logic [15:0] STEP_SMALL     = 16'd3;
    localparam logic [15:0] STEP_LARGE     = 16'd102;
    localparam logic [15:0] DSTEP_MIN      = 16'd3;
    localparam logic [15:0] DSTEP_MAX      = 16'd819;
    localparam logic [15:0] ENC_STEP_RESET = 16'd3;
    localparam logic [15:0] ENC_STEP_BOUND = 16'd1700;

    // Bit sign codes kept by the encoder
    localparam logic [1:0] SIGN_NONE  = 2'd0;
    localparam logic [1:0] SIGN_PLUS  = 2'd1;
    localparam logic [1:0] SIGN_MINUS = 2'd3;

    // floor(42296*d1/32768) and -floor(12130*d2/32768) for d = +1 / -1
    localparam logic signed [17:0] PREV1_PLUS  = 18'sd1;
    localparam logic signed [17:0] PREV1_MINUS = -18'sd2;
    localparam logic signed [17:0] PREV2_PLUS  = 18'sd0;
    localparam logic signed [17:0] PREV2_MINUS = 18'sd1;

    localparam int PROD_W = 17;

    typedef enum logic [1:0] {
        COEF_ENC_LEAK,
        COEF_DEC_LEAK,
        COEF_W_STEP
    } coef_sel_t;

    function automatic logic [15:0] coef_value(input coef_sel_t sel);
        logic [15:0] c;
        case (sel)
            COEF_ENC_LEAK: c = ENC_LEAK;
            COEF_DEC_LEAK: c = DEC_LEAK;
            COEF_W_STEP:   c = W_STEP;
            default:       c = 16'd0;
        endcase
        return c;
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [19:0] v);
        logic signed [15:0] r;
        if (v >= 20'sd32767)
            r = 16'sh7FFF;
        else if (v <= -20'sd32768)
            r = 16'sh8000;
        else
            r = v[15:0];
        return r;
    endfunction

endpackage

FILE: src/cvsd_ifs.sv
// Valid/ready channel interfaces for samples in and coded results out.
// Depends on cvsd_pkg.
interface cvsd_sample_if
    import cvsd_pkg::*;
;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface cvsd_result_if
    import cvsd_pkg::*;
;
    logic               valid;
    logic               ready;
    logic               code_bit;
    logic signed [15:0] decoded_sample;

    modport source (output valid, output code_bit, output decoded_sample, input ready);
    modport sink   (input valid, input code_bit, input decoded_sample, output ready);
endinterface

FILE: src/cvsd_codec_loopback_unit.sv
// CVSD encoder/decoder loopback top level with its step sequencer.
// Depends on cvsd_pkg, cvsd_ifs, cvsd_mul and the assertion macro header.
//
// Each sample item is encoded to one CVSD bit and decoded straight back,
// yielding one result item (code_bit, decoded_sample). An item's result is
// loaded into the output register in state S_FIN, after the sequence has passed
// through S_STEP, S_INTEG, S_DSTEP and S_WSTEP. The single shared Q15 multiplier
// is used four times in turn (encoder step leak, integrator leak, decoder step
// leak, output step weight), the first product registered at the accepting edge.
// One update step for the decoder step (S_DSTEP) sits between the third and fourth
// products, and a final state forms and loads the result. The block takes a new
// sample only between items. The output register holds a finished result while
// the next sample is accepted; a sequence stalls at its last step only if that
// register is still full.
`include "cvsd_codec_loopback_unit_assert.svh"

module cvsd_codec_loopback_unit
    import cvsd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    cvsd_sample_if.sink          samples,
    cvsd_result_if.source        results
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_STEP,
        S_INTEG,
        S_DSTEP,
        S_WSTEP,
        S_FIN
    } state_t;

    state_t             state_reg,   state_next;
    logic [1:0]         sign1_reg,   sign1_next;
    logic [1:0]         sign2_reg,   sign2_next;
    logic [1:0]         hist_reg,    hist_next;
    logic [15:0]        enc_step_reg, enc_step_next;
    logic signed [15:0] integ_reg,   integ_next;
    logic [15:0]        dec_step_reg, dec_step_next;
    logic               bit_reg,     bit_next;
    logic               out_valid_reg, out_valid_next;
    logic               out_bit_reg, out_bit_next;
    logic signed [15:0] out_data_reg, out_data_next;

    logic                     mul_en;
    coef_sel_t                mul_sel;
    logic signed [15:0]       mul_opnd;
    logic signed [PROD_W-1:0] prod;

    logic                     accept;
    logic                     fin_load;
    logic [1:0]               cur_sgn;
    logic                     enc_match;
    logic                     dec_match;
    logic [15:0]              st_sum;
    logic signed [17:0]       prod_ext;
    logic signed [17:0]       st_ext;
    logic signed [17:0]       acc;
    logic [16:0]              ds_raw;
    logic [15:0]              ds_clamped;
    logic signed [17:0]       dacc;
    logic signed [15:0]       cur16;
    logic signed [15:0]       y16;

    cvsd_mul u_mul (
        .clk     (clk),
        .en      (mul_en),
        .sel     (mul_sel),
        .operand (mul_opnd),
        .prod    (prod)
    );

    assign accept   = samples.valid && samples.ready;
    assign fin_load = !out_valid_reg || results.ready;

    assign samples.ready          = (state_reg == S_IDLE);
    assign results.valid          = out_valid_reg;
    assign results.code_bit       = out_bit_reg;
    assign results.decoded_sample = out_data_reg;

    // Operand selection for the shared multiplier
    always_comb
    begin
        mul_en   = 1'b0;
        mul_sel  = COEF_ENC_LEAK;
        mul_opnd = 16'sd0;
        case (state_reg)
            S_IDLE:
            begin
                mul_en   = accept;
                mul_sel  = COEF_ENC_LEAK;
                mul_opnd = $signed(enc_step_reg);
            end
            S_STEP:
            begin
                mul_en   = 1'b1;
                mul_sel  = COEF_ENC_LEAK;
                mul_opnd = integ_reg;
            end
            S_INTEG:
            begin
                mul_en   = 1'b1;
                mul_sel  = COEF_DEC_LEAK;
                mul_opnd = $signed(dec_step_reg);
            end
            S_WSTEP:
            begin
                mul_en   = 1'b1;
                mul_sel  = COEF_W_STEP;
                mul_opnd = $signed(dec_step_reg);
            end
            default:
            begin
                mul_en = 1'b0;
            end
        endcase
    end

    // Datapath around the product
    always_comb
    begin
        cur_sgn   = bit_reg ? SIGN_PLUS : SIGN_MINUS;
        enc_match = (cur_sgn == sign1_reg) && (sign1_reg == sign2_reg);
        dec_match = (bit_reg == hist_reg[0]) && (hist_reg[0] == hist_reg[1]);

        prod_ext = {prod[PROD_W-1], prod};
        st_sum   = prod[15:0] + (enc_match ? STEP_LARGE : STEP_SMALL);
        st_ext   = $signed({2'b00, enc_step_reg});
        acc      = prod_ext + (bit_reg ? st_ext : -st_ext);

        ds_raw   = {1'b0, prod[15:0]} + {1'b0, (dec_match ? STEP_LARGE : STEP_SMALL)};
        if (ds_raw > {1'b0, DSTEP_MAX})
            ds_clamped = DSTEP_MAX;
        else if (ds_raw < {1'b0, DSTEP_MIN})
            ds_clamped = DSTEP_MIN;
        else
            ds_clamped = ds_raw[15:0];

        dacc  = (hist_reg[0] ? PREV1_PLUS : PREV1_MINUS)
              + (hist_reg[1] ? PREV2_PLUS : PREV2_MINUS)
              + (bit_reg ? prod_ext : -prod_ext);
        cur16 = sat16({{2{dacc[17]}}, dacc});
        y16   = sat16({{2{cur16[15]}}, cur16, 2'b00});
    end

    // Sequencer and state updates
    always_comb
    begin
        state_next     = state_reg;
        sign1_next     = sign1_reg;
        sign2_next     = sign2_reg;
        hist_next      = hist_reg;
        enc_step_next  = enc_step_reg;
        integ_next     = integ_reg;
        dec_step_next  = dec_step_reg;
        bit_next       = bit_reg;
        out_valid_next = out_valid_reg && !results.ready;
        out_bit_next   = out_bit_reg;
        out_data_next  = out_data_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    bit_next   = (integ_reg < samples.sample);
                    state_next = S_STEP;
                end
            end
            S_STEP:
            begin
                enc_step_next = st_sum;
                sign2_next    = sign1_reg;
                sign1_next    = cur_sgn;
                state_next    = S_INTEG;
            end
            S_INTEG:
            begin
                integ_next = sat16({{2{acc[17]}}, acc});
                state_next = S_DSTEP;
            end
            S_DSTEP:
            begin
                dec_step_next = ds_clamped;
                state_next    = S_WSTEP;
            end
            S_WSTEP:
            begin
                state_next = S_FIN;
            end
            S_FIN:
            begin
                // hold here until the output register is free
                if (fin_load)
                begin
                    out_valid_next = 1'b1;
                    out_bit_next   = bit_reg;
                    out_data_next  = y16;
                    hist_next      = {hist_reg[0], bit_reg};
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sign1_reg     <= SIGN_NONE;
            sign2_reg     <= SIGN_NONE;
            hist_reg      <= 2'b00;
            enc_step_reg  <= ENC_STEP_RESET;
            integ_reg     <= 16'sd0;
            dec_step_reg  <= DSTEP_MIN;
            bit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            out_bit_reg   <= 1'b0;
            out_data_reg  <= 16'sd0;
        end
        else
        begin
            state_reg     <= state_next;
            sign1_reg     <= sign1_next;
            sign2_reg     <= sign2_next;
            hist_reg      <= hist_next;
            enc_step_reg  <= enc_step_next;
            integ_reg     <= integ_next;
            dec_step_reg  <= dec_step_next;
            bit_reg       <= bit_next;
            out_valid_reg <= out_valid_next;
            out_bit_reg   <= out_bit_next;
            out_data_reg  <= out_data_next;
        end
    end

    `CVSD_ASSERT_IMP(a_enc_step_bound, clk, rst_n, 1'b1, enc_step_reg < ENC_STEP_BOUND)
    `CVSD_ASSERT_IMP(a_dec_step_range, clk, rst_n, 1'b1, (dec_step_reg >= DSTEP_MIN) && (dec_step_reg <= DSTEP_MAX))
    `CVSD_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, samples.valid && samples.ready, !samples.ready)
    `CVSD_ASSERT_NEXT(a_result_loaded, clk, rst_n, (state_reg == S_FIN) && fin_load, results.valid && (results.code_bit == $past(bit_reg)))

endmodule

FILE: src/cvsd_mul.sv
// Shared Q15 coefficient multiplier: constant coefficient times signed operand,
// arithmetic shift right by 15, registered. Depends on cvsd_pkg.
module cvsd_mul
    import cvsd_pkg::*;
(
    input  logic                     clk,
    input  logic                     en,
    input  coef_sel_t                sel,
    input  logic signed [15:0]       operand,
    output logic signed [PROD_W-1:0] prod
);

    logic signed [32:0]       full;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;

    always_comb
    begin
        full      = $signed({1'b0, coef_value(sel)}) * operand;
        // floor divide by 2^15; magnitude stays below 2^31
        prod_next = full[15+PROD_W-1:15];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule

FILE: tb/tb.sv
// Self-checking testbench for the CVSD encode/decode loopback unit.
// Depends on cvsd_pkg and the sample/result channel interfaces in cvsd_ifs.
// Items go in with bursty valid and are checked against a cycle-free codec predictor.
module tb;
    import cvsd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam longint LEAK_ENC    = 30782;
    localparam longint LEAK_DEC    = 32260;
    localparam longint WT_PREV1    = 42296;
    localparam longint WT_PREV2    = 12130;
    localparam longint WT_STEP     = 32260;
    localparam longint INC_SMALL   = 3;
    localparam longint INC_LARGE   = 102;
    localparam longint DSTEP_LO    = 3;
    localparam longint DSTEP_HI    = 819;
    localparam longint GAIN        = 4;
    localparam int     RANDOM_ITEMS   = 1350;
    localparam int     WATCHDOG_LIMIT = 2000;
    localparam int     DRAIN_CYCLES   = 24;

    typedef struct packed {
        logic               code_bit;
        logic signed [15:0] decoded_sample;
    } codec_result_t;

    logic clk;
    logic rst_n = 1'b0;

    cvsd_sample_if sample_ch ();
    cvsd_result_if result_ch ();

    cvsd_codec_loopback_unit dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (sample_ch),
        .results (result_ch)
    );

    // Drive channel inputs from local registers so they are known from time zero
    logic               drv_valid  = 1'b0;
    logic signed [15:0] drv_sample = '0;
    logic               rdy_r      = 1'b0;

    assign sample_ch.valid  = drv_valid;
    assign sample_ch.sample = drv_sample;
    assign result_ch.ready  = rdy_r;

    logic signed [15:0] pending_q[$];
    codec_result_t      result_q[$];

    // Codec predictor state
    logic [1:0] pred_sign1 = SIGN_NONE;
    logic [1:0] pred_sign2 = SIGN_NONE;
    logic [1:0] pred_hist  = 2'b00;
    longint     pred_enc_step = 3;
    longint     pred_integ    = 0;
    longint     pred_dec_step = 3;

    int errors       = 0;
    int sent_cnt     = 0;
    int checked_cnt  = 0;
    int max_enc_step = 0;
    int dstep_top    = 0;
    int large_incs   = 0;
    int burst_left   = 0;
    int gap_left     = 0;
    int idle_cycles  = 0;
    logic [31:0] stall_pat = '1;
    int          stall_idx = 0;

    function automatic longint clip16(input longint v);
        longint r;
        if (v >= 32767)
            r = 32767;
        else if (v <= -32768)
            r = -32768;
        else
            r = v;
        return r;
    endfunction

    task automatic predict_codec(input logic signed [15:0] x);
        logic          hit;
        logic [1:0]    sgn;
        longint        dir;
        longint        st;
        longint        d1;
        longint        d2;
        longint        ds;
        longint        dacc;
        longint        cur;
        codec_result_t r;
        hit = pred_integ < longint'(x);
        sgn = hit ? SIGN_PLUS : SIGN_MINUS;
        dir = hit ? 1 : -1;

        // encoder: leak the step, grow it, then leak and move the integrator
        st = (LEAK_ENC * pred_enc_step) >>> 15;
        if (sgn == pred_sign1 && pred_sign1 == pred_sign2)
        begin
            st += INC_LARGE;
            large_incs++;
        end
        else
            st += INC_SMALL;
        pred_enc_step = st;
        if (st > max_enc_step)
            max_enc_step = int'(st);
        pred_integ = clip16(((LEAK_ENC * pred_integ) >>> 15) + st * dir);
        pred_sign2 = pred_sign1;
        pred_sign1 = sgn;

        // decoder: a zero history bit counts as minus
        d1 = pred_hist[0] ? 1 : -1;
        d2 = pred_hist[1] ? 1 : -1;
        ds = (LEAK_DEC * pred_dec_step) >>> 15;
        if (dir == d1 && d1 == d2)
            ds += INC_LARGE;
        else
            ds += INC_SMALL;
        if (ds > DSTEP_HI)
            ds = DSTEP_HI;
        if (ds < DSTEP_LO)
            ds = DSTEP_LO;
        if (ds == DSTEP_HI)
            dstep_top++;
        pred_dec_step = ds;
        dacc = ((WT_PREV1 * d1) >>> 15) - ((WT_PREV2 * d2) >>> 15)
             + ((WT_STEP * ds) >>> 15) * dir;
        cur = clip16(dacc);
        pred_hist = {pred_hist[0], hit};

        r.code_bit       = hit;
        r.decoded_sample = 16'(clip16(cur * GAIN));
        result_q.push_back(r);
    endtask

    function automatic logic signed [15:0] to_s16(input int v);
        int c;
        c = v;
        if (c > 32767)
            c = 32767;
        if (c < -32768)
            c = -32768;
        return 16'(c);
    endfunction

    // Random segments: noise, held levels, triangle waves and near-silence
    task automatic fill_random();
        int added;
        int mode;
        int len;
        int level;
        int amp;
        int per;
        int pos;
        int v;
        added = 0;
        while (added < RANDOM_ITEMS)
        begin
            mode = $urandom_range(0, 9);
            len  = $urandom_range(5, 40);
            level = int'($urandom_range(0, 65535)) - 32768;
            if ($urandom_range(0, 3) == 0)
                level = $urandom_range(0, 1) ? 32767 : -32768;
            amp = $urandom_range(50, 32767);
            per = $urandom_range(4, 80);
            for (int i = 0; i < len; i++)
            begin
                if (mode < 2)
                    v = int'($urandom_range(0, 65535)) - 32768;
                else if (mode < 4)
                    v = level;
                else if (mode < 8)
                begin
                    pos = i % per;
                    if (pos < per / 2)
                        v = -amp + (4 * amp * pos) / per;
                    else
                        v = amp - (4 * amp * (pos - per / 2)) / per;
                end
                else
                    v = int'($urandom_range(0, 128)) - 64;
                pending_q.push_back(to_s16(v));
                added++;
            end
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Sender: bursts of random length separated by random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drv_valid  <= 1'b0;
            drv_sample <= '0;
            burst_left <= 0;
            gap_left   <= 0;
        end
        else if (!drv_valid || sample_ch.ready)
        begin
            if (drv_valid)
            begin
                predict_codec(drv_sample);
                void'(pending_q.pop_front());
                sent_cnt++;
            end
            if (gap_left > 0)
            begin
                gap_left  <= gap_left - 1;
                drv_valid <= 1'b0;
            end
            else if (pending_q.size() > 0)
            begin
                drv_valid  <= 1'b1;
                drv_sample <= pending_q[0];
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                drv_valid <= 1'b0;
        end
    end

    // Receiver: walk a 32-bit ready pattern, pick a new one on wrap
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rdy_r     <= 1'b0;
            stall_idx <= 0;
            stall_pat <= '1;
        end
        else
        begin
            if (result_ch.valid && rdy_r)
            begin
                if (result_q.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("ERROR: unexpected result item code_bit=%0b decoded=%0d",
                                 result_ch.code_bit, result_ch.decoded_sample);
                end
                else
                begin
                    codec_result_t want;
                    want = result_q.pop_front();
                    checked_cnt++;
                    if (want.code_bit !== result_ch.code_bit
                        || want.decoded_sample !== result_ch.decoded_sample)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("ERROR: result %0d: expected bit=%0b dec=%0d, got bit=%0b dec=%0d",
                                     checked_cnt, want.code_bit, want.decoded_sample,
                                     result_ch.code_bit, result_ch.decoded_sample);
                    end
                end
            end
            rdy_r <= stall_pat[stall_idx];
            if (stall_idx == 31)
            begin
                stall_idx <= 0;
                case ($urandom_range(0, 3))
                    0: stall_pat <= '1;
                    1: stall_pat <= $urandom;
                    2: stall_pat <= $urandom & $urandom & $urandom;
                    default: stall_pat <= $urandom | $urandom;
                endcase
            end
            else
                stall_idx <= stall_idx + 1;
        end
    end

    // Watchdog: end the run if nothing moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (drv_valid && sample_ch.ready) || (result_ch.valid && rdy_r))
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial
    begin
        // first sample of zero exercises the start-up history
        pending_q.push_back(16'sd0);
        for (int i = 0; i < 6; i++)
            pending_q.push_back(16'sh7FFF);
        for (int i = 0; i < 6; i++)
            pending_q.push_back(16'sh8000);
        pending_q.push_back(16'sd0);
        pending_q.push_back(-16'sd1);
        pending_q.push_back(16'sd1);
        pending_q.push_back(16'sh5555);
        pending_q.push_back(16'shAAAA);
        pending_q.push_back(16'sh7FFF);
        pending_q.push_back(16'sh8000);
        pending_q.push_back(16'sd0);
        pending_q.push_back(16'sd100);
        pending_q.push_back(-16'sd100);
        fill_random();

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        wait (pending_q.size() == 0 && !drv_valid && result_q.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d samples and %0d checked results, %0d mismatches.",
                 sent_cnt, checked_cnt, errors);
        $display("Encoder step peaked at %0d with %0d large increments; decoder step hit %0d %0d times.",
                 max_enc_step, large_incs, DSTEP_HI, dstep_top);
        if (errors == 0 && result_q.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
